// File: src/rdwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdwc_pkg;

    // Word kinds
    localparam logic [2:0] KIND_BEGIN   = 3'd0;
    localparam logic [2:0] KIND_END     = 3'd1;
    localparam logic [2:0] KIND_GAP     = 3'd2;
    localparam logic [2:0] KIND_DUMMY   = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;
    localparam logic [2:0] KIND_HIT     = 3'd5;
    localparam logic [2:0] KIND_INVALID = 3'd6;

    // Error kinds: chip code minus 28
    localparam logic [1:0] ERR_FIFO_NF  = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
    localparam logic [1:0] ERR_TRAILER  = 2'd2;
    localparam logic [1:0] ERR_EVENT    = 2'd3;

    // Special chip codes
    localparam logic [4:0] CHIP_GAP       = 5'd26;
    localparam logic [4:0] CHIP_DUMMY     = 5'd27;
    localparam logic [4:0] CHIP_LAST_ROC  = 5'd25;

    localparam logic [5:0] CHANNEL_LIMIT  = 6'd37;

    typedef struct packed {
        logic [2:0] word_kind;
        logic [5:0] channel_number;
        logic [4:0] chip_number;
        logic [4:0] double_column;
        logic [7:0] pixel_address;
        logic [7:0] low_byte;
        logic [1:0] error_kind;
        logic [5:0] timeout_first_channel;
        logic [4:0] group_bits;
        logic [4:0] error_flags;
        logic [1:0] fsm_status;
        logic [7:0] error_event;
    } result_t;

    // First channel of each timeout group, less one
    function automatic logic [4:0] group_offset(input logic [2:0] idx);
        logic [4:0] off;
        case (idx)
            3'd0:    off = 5'd0;
            3'd1:    off = 5'd4;
            3'd2:    off = 5'd9;
            3'd3:    off = 5'd13;
            3'd4:    off = 5'd18;
            3'd5:    off = 5'd22;
            3'd6:    off = 5'd27;
            3'd7:    off = 5'd31;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// File: src/rdwc_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module rdwc_decode
(
    input  wire logic [31:0]      word,
    output rdwc_pkg::result_t     result
);

    logic [5:0] chan;
    logic [4:0] chip;
    logic [1:0] ekind;

    assign chan  = word[31:26];
    assign chip  = word[25:21];
    assign ekind = chip[1:0];

    always_comb
    begin
        result                       = '0;
        result.channel_number        = chan;
        result.chip_number           = chip;

        if (word[27:0] == 28'd0)
        begin
            result.word_kind = rdwc_pkg::KIND_BEGIN;
        end
        else if (chip > rdwc_pkg::CHIP_LAST_ROC)
        begin
            if (word == 32'hffff_ffff)
            begin
                result.word_kind = rdwc_pkg::KIND_END;
            end
            else if (chip == rdwc_pkg::CHIP_GAP)
            begin
                result.word_kind = rdwc_pkg::KIND_GAP;
                result.low_byte  = word[7:0];
            end
            else if (chip == rdwc_pkg::CHIP_DUMMY)
            begin
                result.word_kind = rdwc_pkg::KIND_DUMMY;
                result.low_byte  = word[7:0];
            end
            else
            begin
                result.word_kind   = rdwc_pkg::KIND_ERROR;
                result.error_kind  = ekind;
                result.error_event = word[20:13];
                case (ekind)
                    rdwc_pkg::ERR_TIMEOUT:
                    begin
                        result.timeout_first_channel =
                            {1'b0, rdwc_pkg::group_offset(word[10:8])} + 6'd1;
                        result.group_bits = word[4:0];
                    end
                    rdwc_pkg::ERR_EVENT:
                    begin
                        result.low_byte = word[7:0];
                    end
                    rdwc_pkg::ERR_TRAILER:
                    begin
                        result.low_byte       = word[7:0];
                        result.fsm_status     = word[10:9];
                        result.error_flags[0] = word[11];
                        result.error_flags[1] = word[8];
                        result.error_flags[2] = (word[11:8] == 4'd0);
                    end
                    default:
                    begin
                        // FIFO nearly full
                        result.group_bits     = word[4:0];
                        result.error_flags[3] = word[6];
                        result.error_flags[4] = word[7];
                    end
                endcase
            end
        end
        else if (chan != 6'd0 && chan < rdwc_pkg::CHANNEL_LIMIT)
        begin
            result.word_kind     = rdwc_pkg::KIND_HIT;
            result.double_column = word[20:16];
            result.pixel_address = word[15:8];
            result.low_byte      = word[7:0];
        end
        else
        begin
            result.word_kind = rdwc_pkg::KIND_INVALID;
        end
    end

endmodule

`default_nettype wire

// File: src/readout_data_word_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle; busy stays low, an item may start every cycle.
// Path: input word register, field decode, result register strobed by done.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_n low, asynchronous) clears the pipeline valid bits; no result follows.
module readout_data_word_classifier_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] raw_word,
    output logic             done,
    output logic [2:0]       word_kind,
    output logic [5:0]       channel_number,
    output logic [4:0]       chip_number,
    output logic [4:0]       double_column,
    output logic [7:0]       pixel_address,
    output logic [7:0]       low_byte,
    output logic [1:0]       error_kind,
    output logic [5:0]       timeout_first_channel,
    output logic [4:0]       group_bits,
    output logic [4:0]       error_flags,
    output logic [1:0]       fsm_status,
    output logic [7:0]       error_event
);

    logic              in_valid_reg;
    logic [31:0]       word_reg;
    logic              done_reg;
    rdwc_pkg::result_t result_next;
    rdwc_pkg::result_t result_reg;
    logic              accept;

    // Pipeline never backs up, so the port is always open
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= raw_word;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    rdwc_decode u_decode
    (
        .word   (word_reg),
        .result (result_next)
    );

    assign done                  = done_reg;
    assign word_kind             = result_reg.word_kind;
    assign channel_number        = result_reg.channel_number;
    assign chip_number           = result_reg.chip_number;
    assign double_column         = result_reg.double_column;
    assign pixel_address         = result_reg.pixel_address;
    assign low_byte              = result_reg.low_byte;
    assign error_kind            = result_reg.error_kind;
    assign timeout_first_channel = result_reg.timeout_first_channel;
    assign group_bits            = result_reg.group_bits;
    assign error_flags           = result_reg.error_flags;
    assign fsm_status            = result_reg.fsm_status;
    assign error_event           = result_reg.error_event;

endmodule

`default_nettype wire

// File: bench/readout_data_word_classifier_top_tb.sv
`timescale 1ns / 1ps

module readout_data_word_classifier_top_tb;

    import rdwc_pkg::*;

    localparam logic [4:0] CHIP_ERR_BASE = 5'd28;
    localparam int         RANDOM_WORDS  = 1730;
    localparam int         DRAIN_LIMIT   = 1000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] raw_word;
    logic        done;
    logic [2:0]  word_kind;
    logic [5:0]  channel_number;
    logic [4:0]  chip_number;
    logic [4:0]  double_column;
    logic [7:0]  pixel_address;
    logic [7:0]  low_byte;
    logic [1:0]  error_kind;
    logic [5:0]  timeout_first_channel;
    logic [4:0]  group_bits;
    logic [4:0]  error_flags;
    logic [1:0]  fsm_status;
    logic [7:0]  error_event;

    result_t pending_results[$];
    int      failures;
    int      words_sent;
    int      idle_max;
    int      kind_seen[7];

    readout_data_word_classifier_top u_top
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .start                 (start),
        .busy                  (busy),
        .raw_word              (raw_word),
        .done                  (done),
        .word_kind             (word_kind),
        .channel_number        (channel_number),
        .chip_number           (chip_number),
        .double_column         (double_column),
        .pixel_address         (pixel_address),
        .low_byte              (low_byte),
        .error_kind            (error_kind),
        .timeout_first_channel (timeout_first_channel),
        .group_bits            (group_bits),
        .error_flags           (error_flags),
        .fsm_status            (fsm_status),
        .error_event           (error_event)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Channel of bit 0 in a timeout group
    function automatic logic [5:0] timeout_group_first(input logic [2:0] grp);
        logic [5:0] first;
        case (grp)
            3'd0:    first = 6'd1;
            3'd1:    first = 6'd5;
            3'd2:    first = 6'd10;
            3'd3:    first = 6'd14;
            3'd4:    first = 6'd19;
            3'd5:    first = 6'd23;
            3'd6:    first = 6'd28;
            default: first = 6'd32;
        endcase
        return first;
    endfunction

    function automatic result_t classify_word(input logic [31:0] w);
        result_t    r;
        logic [5:0] chan;
        logic [4:0] chip;
        logic [4:0] err_code;
        r    = '0;
        chan = w[31:26];
        chip = w[25:21];
        r.channel_number = chan;
        r.chip_number    = chip;
        if (w[27:0] == 28'd0)
        begin
            r.word_kind = KIND_BEGIN;
        end
        else if (chip > CHIP_LAST_ROC)
        begin
            // all ones carries chip code 31 but is the end-of-event marker
            if (&w)
            begin
                r.word_kind = KIND_END;
            end
            else if (chip == CHIP_GAP)
            begin
                r.word_kind = KIND_GAP;
                r.low_byte  = w[7:0];
            end
            else if (chip == CHIP_DUMMY)
            begin
                r.word_kind = KIND_DUMMY;
                r.low_byte  = w[7:0];
            end
            else
            begin
                err_code      = chip - CHIP_ERR_BASE;
                r.word_kind   = KIND_ERROR;
                r.error_kind  = err_code[1:0];
                r.error_event = w[20:13];
                case (r.error_kind)
                    ERR_TIMEOUT:
                    begin
                        r.timeout_first_channel = timeout_group_first(w[10:8]);
                        r.group_bits            = w[4:0];
                    end
                    ERR_EVENT:
                    begin
                        r.low_byte = w[7:0];
                    end
                    ERR_TRAILER:
                    begin
                        r.low_byte    = w[7:0];
                        r.fsm_status  = w[10:9];
                        r.error_flags = {2'b00, (w[11:8] == 4'd0), w[8], w[11]};
                    end
                    default:
                    begin
                        r.group_bits  = w[4:0];
                        r.error_flags = {w[7], w[6], 3'b000};
                    end
                endcase
            end
        end
        else if (chan != 6'd0 && chan < CHANNEL_LIMIT)
        begin
            r.word_kind     = KIND_HIT;
            r.double_column = w[20:16];
            r.pixel_address = w[15:8];
            r.low_byte      = w[7:0];
        end
        else
        begin
            r.word_kind = KIND_INVALID;
        end
        return r;
    endfunction

    function automatic logic [31:0] make_word(input logic [5:0] chan, input logic [4:0] chip,
                                              input logic [20:0] rest);
        return {chan, chip, rest};
    endfunction

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobe with no word pending");
                failures++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("word_kind", 32'(exp_r.word_kind), 32'(word_kind));
                check_field("channel_number", 32'(exp_r.channel_number),
                            32'(channel_number));
                check_field("chip_number", 32'(exp_r.chip_number), 32'(chip_number));
                check_field("double_column", 32'(exp_r.double_column),
                            32'(double_column));
                check_field("pixel_address", 32'(exp_r.pixel_address),
                            32'(pixel_address));
                check_field("low_byte", 32'(exp_r.low_byte), 32'(low_byte));
                check_field("error_kind", 32'(exp_r.error_kind), 32'(error_kind));
                check_field("timeout_first_channel", 32'(exp_r.timeout_first_channel),
                            32'(timeout_first_channel));
                check_field("group_bits", 32'(exp_r.group_bits), 32'(group_bits));
                check_field("error_flags", 32'(exp_r.error_flags), 32'(error_flags));
                check_field("fsm_status", 32'(exp_r.fsm_status), 32'(fsm_status));
                check_field("error_event", 32'(exp_r.error_event), 32'(error_event));
                kind_seen[exp_r.word_kind]++;
            end
        end
    end

    // Called just after a rising edge; returns just after the edge that takes the item.
    task automatic issue_word(input logic [31:0] w);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        raw_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(classify_word(w));
        words_sent++;
    endtask

    task automatic test_frame_words();
        issue_word(32'h0000_0000);
        issue_word(32'hFC00_0000);
        issue_word(32'h9000_0000);
        issue_word(32'hFFFF_FFFF);
        // one bit short of an end word: event-number error on chip 31
        issue_word(32'hFFFF_FFFE);
        issue_word(32'h0FFF_FFFF);
    endtask

    task automatic test_gap_dummy();
        issue_word(make_word(6'd5, CHIP_GAP, 21'h1F_FFFF));
        issue_word(make_word(6'd63, CHIP_DUMMY, 21'h00_00A5));
    endtask

    task automatic test_error_words();
        issue_word(make_word(6'd1, CHIP_ERR_BASE + 5'(ERR_FIFO_NF), 21'h1F_FFDF));
        issue_word(make_word(6'd0, CHIP_ERR_BASE + 5'(ERR_FIFO_NF), 21'h00_0020));
        issue_word(make_word(6'd7, CHIP_ERR_BASE + 5'(ERR_TIMEOUT), 21'h00_001F));
        issue_word(make_word(6'd40, CHIP_ERR_BASE + 5'(ERR_TIMEOUT), 21'h1F_E715));
        issue_word(make_word(6'd12, CHIP_ERR_BASE + 5'(ERR_TRAILER), 21'h0A_A0FF));
        issue_word(make_word(6'd36, CHIP_ERR_BASE + 5'(ERR_TRAILER), 21'h15_5F00));
        issue_word(make_word(6'd2, CHIP_ERR_BASE + 5'(ERR_EVENT), 21'h1F_E0C3));
    endtask

    task automatic test_hits_and_invalid();
        issue_word(make_word(6'd1, 5'd0, 21'h1F_FFFF));
        issue_word(make_word(6'd36, CHIP_LAST_ROC, 21'h00_0001));
        issue_word(make_word(6'd0, 5'd5, 21'h12_3456));
        issue_word(make_word(6'd37, 5'd17, 21'h1F_FFFF));
        issue_word(make_word(6'd63, CHIP_LAST_ROC, 21'h0A_BCDE));
    endtask

    task automatic test_random_stream(input int n);
        logic [31:0] w;
        int          pick;
        for (int i = 0; i < n; i++)
        begin
            // vary the sender gaps per block, including stretches with none
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_max = 0;
                    1:       idle_max = 3;
                    default: idle_max = 17;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 15)
                w = $urandom();
            else if (pick < 45)
                w = make_word(6'($urandom_range(1, 36)), 5'($urandom_range(0, 25)),
                              21'($urandom()));
            else if (pick < 60)
                w = make_word(6'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(37, 63)),
                              5'($urandom_range(0, 25)), 21'($urandom()));
            else if (pick < 85)
                w = make_word(6'($urandom()), 5'($urandom_range(28, 31)), 21'($urandom()));
            else if (pick < 93)
                w = make_word(6'($urandom()), 5'($urandom_range(26, 27)), 21'($urandom()));
            else if (pick < 97)
                w = {4'($urandom()), 28'd0};
            else
                w = 32'hFFFF_FFFF;
            issue_word(w);
        end
    endtask

    initial
    begin
        int drain_cycles;
        failures   = 0;
        words_sent = 0;
        idle_max   = 4;
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        raw_word <= 32'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_words();
        test_gap_dummy();
        test_error_words();
        test_hits_and_invalid();
        test_random_stream(RANDOM_WORDS);

        start <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end
        repeat (5) @(posedge clk);

        $display("Classified %0d words: begin %0d, end %0d, gap %0d, dummy %0d,",
                 words_sent, kind_seen[KIND_BEGIN], kind_seen[KIND_END],
                 kind_seen[KIND_GAP], kind_seen[KIND_DUMMY]);
        $display("  error %0d, hit %0d, invalid channel %0d; %0d mismatches",
                 kind_seen[KIND_ERROR], kind_seen[KIND_HIT], kind_seen[KIND_INVALID],
                 failures);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
src/rdwc_pkg.sv
src/rdwc_decode.sv
src/readout_data_word_classifier_top.sv
bench/readout_data_word_classifier_top_tb.sv
